### src/kbsc_pkg.sv
package kbsc_pkg;

    localparam int unsigned SCAN_W = 8;
    localparam int unsigned CHAR_W = 7;
    localparam int unsigned KIND_W = 2;
    localparam int unsigned TERM_W = 2;
    localparam int unsigned IDX_W  = 6;

    // stream payload widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 16;

    // first code that is not in the character tables
    localparam logic [SCAN_W-1:0] MAP_SIZE = 8'd59;

    // scan code set 1 codes
    localparam logic [SCAN_W-1:0] SC_CAPS      = 8'h3A;
    localparam logic [SCAN_W-1:0] SC_LCTRL_DN  = 8'h1D;
    localparam logic [SCAN_W-1:0] SC_LCTRL_UP  = 8'h9D;
    localparam logic [SCAN_W-1:0] SC_LALT_DN   = 8'h38;
    localparam logic [SCAN_W-1:0] SC_LALT_UP   = 8'hB8;
    localparam logic [SCAN_W-1:0] SC_LSHIFT_DN = 8'h2A;
    localparam logic [SCAN_W-1:0] SC_LSHIFT_UP = 8'hAA;
    localparam logic [SCAN_W-1:0] SC_RSHIFT_DN = 8'h36;
    localparam logic [SCAN_W-1:0] SC_RSHIFT_UP = 8'hB6;
    localparam logic [SCAN_W-1:0] SC_F1        = 8'h3B;
    localparam logic [SCAN_W-1:0] SC_F2        = 8'h3C;
    localparam logic [SCAN_W-1:0] SC_F3        = 8'h3D;

    // event kinds
    localparam logic [KIND_W-1:0] EV_CHAR  = 2'd0;
    localparam logic [KIND_W-1:0] EV_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] EV_INTR  = 2'd2;
    localparam logic [KIND_W-1:0] EV_TERM  = 2'd3;

    // terminal numbers
    localparam logic [TERM_W-1:0] TERM_0 = 2'd0;
    localparam logic [TERM_W-1:0] TERM_1 = 2'd1;
    localparam logic [TERM_W-1:0] TERM_2 = 2'd2;

    // ascii constants used by the decoder
    localparam logic [CHAR_W-1:0] CHAR_L     = 7'h6C;
    localparam logic [CHAR_W-1:0] CHAR_C     = 7'h63;
    localparam logic [CHAR_W-1:0] CHAR_LO_A  = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 7'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 7'h5A;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 7'h20;

    typedef struct packed {
        logic shift_held;
        logic caps_on;
        logic ctrl_held;
        logic alt_held;
    } flags_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [CHAR_W-1:0] char_code;
        logic [TERM_W-1:0] terminal_number;
    } event_t;

    // unshifted layout
    function automatic logic [CHAR_W-1:0] plain_char(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = '0;
        case (idx)
            6'd2:  c = 7'h31;
            6'd3:  c = 7'h32;
            6'd4:  c = 7'h33;
            6'd5:  c = 7'h34;
            6'd6:  c = 7'h35;
            6'd7:  c = 7'h36;
            6'd8:  c = 7'h37;
            6'd9:  c = 7'h38;
            6'd10: c = 7'h39;
            6'd11: c = 7'h30;
            6'd12: c = 7'h2D;
            6'd13: c = 7'h3D;
            6'd14: c = 7'h08;
            6'd16: c = 7'h71;
            6'd17: c = 7'h77;
            6'd18: c = 7'h65;
            6'd19: c = 7'h72;
            6'd20: c = 7'h74;
            6'd21: c = 7'h79;
            6'd22: c = 7'h75;
            6'd23: c = 7'h69;
            6'd24: c = 7'h6F;
            6'd25: c = 7'h70;
            6'd26: c = 7'h5B;
            6'd27: c = 7'h5D;
            6'd28: c = 7'h0A;
            6'd30: c = 7'h61;
            6'd31: c = 7'h73;
            6'd32: c = 7'h64;
            6'd33: c = 7'h66;
            6'd34: c = 7'h67;
            6'd35: c = 7'h68;
            6'd36: c = 7'h6A;
            6'd37: c = 7'h6B;
            6'd38: c = 7'h6C;
            6'd39: c = 7'h3B;
            6'd40: c = 7'h27;
            6'd41: c = 7'h60;
            6'd43: c = 7'h5C;
            6'd44: c = 7'h7A;
            6'd45: c = 7'h78;
            6'd46: c = 7'h63;
            6'd47: c = 7'h76;
            6'd48: c = 7'h62;
            6'd49: c = 7'h6E;
            6'd50: c = 7'h6D;
            6'd51: c = 7'h2C;
            6'd52: c = 7'h2E;
            6'd53: c = 7'h2F;
            6'd57: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

    // shifted layout
    function automatic logic [CHAR_W-1:0] shift_char(input logic [IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        c = '0;
        case (idx)
            6'd2:  c = 7'h21;
            6'd3:  c = 7'h40;
            6'd4:  c = 7'h23;
            6'd5:  c = 7'h24;
            6'd6:  c = 7'h25;
            6'd7:  c = 7'h5E;
            6'd8:  c = 7'h26;
            6'd9:  c = 7'h2A;
            6'd10: c = 7'h28;
            6'd11: c = 7'h29;
            6'd12: c = 7'h5F;
            6'd13: c = 7'h2B;
            6'd14: c = 7'h08;
            6'd16: c = 7'h51;
            6'd17: c = 7'h57;
            6'd18: c = 7'h45;
            6'd19: c = 7'h52;
            6'd20: c = 7'h54;
            6'd21: c = 7'h59;
            6'd22: c = 7'h55;
            6'd23: c = 7'h49;
            6'd24: c = 7'h4F;
            6'd25: c = 7'h50;
            6'd26: c = 7'h7B;
            6'd27: c = 7'h7D;
            6'd28: c = 7'h0A;
            6'd30: c = 7'h41;
            6'd31: c = 7'h53;
            6'd32: c = 7'h44;
            6'd33: c = 7'h46;
            6'd34: c = 7'h47;
            6'd35: c = 7'h48;
            6'd36: c = 7'h4A;
            6'd37: c = 7'h4B;
            6'd38: c = 7'h4C;
            6'd39: c = 7'h3A;
            6'd40: c = 7'h22;
            6'd41: c = 7'h7E;
            6'd43: c = 7'h7C;
            6'd44: c = 7'h5A;
            6'd45: c = 7'h58;
            6'd46: c = 7'h43;
            6'd47: c = 7'h56;
            6'd48: c = 7'h42;
            6'd49: c = 7'h4E;
            6'd50: c = 7'h4D;
            6'd51: c = 7'h3C;
            6'd52: c = 7'h3E;
            6'd53: c = 7'h3F;
            6'd57: c = 7'h20;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

### src/kbsc_decode.sv
module kbsc_decode
(
    input  logic [kbsc_pkg::SCAN_W-1:0] scan_byte,
    input  kbsc_pkg::flags_t            flags,
    output kbsc_pkg::flags_t            flags_next,
    output logic                        has_event,
    output kbsc_pkg::event_t            ev
);

    logic                          is_press;
    logic [kbsc_pkg::IDX_W-1:0]    idx;
    logic [kbsc_pkg::CHAR_W-1:0]   plain_c;
    logic [kbsc_pkg::CHAR_W-1:0]   mapped_c;
    logic [kbsc_pkg::CHAR_W-1:0]   final_c;
    logic                          is_letter;

    // modifier flag update
    always_comb
    begin
        flags_next = flags;
        is_press   = 1'b0;
        unique case (scan_byte)
            kbsc_pkg::SC_CAPS:
            begin
                flags_next.caps_on = ~flags.caps_on;
                is_press           = 1'b1;
            end
            kbsc_pkg::SC_LCTRL_DN:
            begin
                flags_next.ctrl_held = 1'b1;
                is_press             = 1'b1;
            end
            kbsc_pkg::SC_LALT_DN:
            begin
                flags_next.alt_held = 1'b1;
                is_press            = 1'b1;
            end
            kbsc_pkg::SC_LSHIFT_DN, kbsc_pkg::SC_RSHIFT_DN:
            begin
                flags_next.shift_held = 1'b1;
                is_press              = 1'b1;
            end
            kbsc_pkg::SC_LCTRL_UP:  flags_next.ctrl_held  = 1'b0;
            kbsc_pkg::SC_LALT_UP:   flags_next.alt_held   = 1'b0;
            kbsc_pkg::SC_LSHIFT_UP, kbsc_pkg::SC_RSHIFT_UP:
                flags_next.shift_held = 1'b0;
            default: ;
        endcase
    end

    // table lookup and case swap
    assign idx      = scan_byte[kbsc_pkg::IDX_W-1:0];
    assign plain_c  = kbsc_pkg::plain_char(idx);
    assign mapped_c = flags.shift_held ? kbsc_pkg::shift_char(idx) : plain_c;
    assign is_letter = ((mapped_c >= kbsc_pkg::CHAR_LO_A) && (mapped_c <= kbsc_pkg::CHAR_LO_Z))
                    || ((mapped_c >= kbsc_pkg::CHAR_UP_A) && (mapped_c <= kbsc_pkg::CHAR_UP_Z));
    assign final_c  = (flags.caps_on && is_letter) ? (mapped_c ^ kbsc_pkg::CASE_BIT) : mapped_c;

    always_comb
    begin
        has_event           = 1'b0;
        ev.event_kind       = kbsc_pkg::EV_CHAR;
        ev.char_code        = '0;
        ev.terminal_number  = kbsc_pkg::TERM_0;
        if (!is_press)
        begin
            if (flags_next.alt_held)
            begin
                ev.event_kind = kbsc_pkg::EV_TERM;
                unique case (scan_byte)
                    kbsc_pkg::SC_F1: has_event = 1'b1;
                    kbsc_pkg::SC_F2:
                    begin
                        has_event          = 1'b1;
                        ev.terminal_number = kbsc_pkg::TERM_1;
                    end
                    kbsc_pkg::SC_F3:
                    begin
                        has_event          = 1'b1;
                        ev.terminal_number = kbsc_pkg::TERM_2;
                    end
                    default: has_event = 1'b0;
                endcase
            end
            else if (scan_byte < kbsc_pkg::MAP_SIZE)
            begin
                // ctrl shortcuts only inside the table
                if (flags.ctrl_held && (plain_c == kbsc_pkg::CHAR_L))
                begin
                    has_event     = 1'b1;
                    ev.event_kind = kbsc_pkg::EV_CLEAR;
                end
                else if (flags.ctrl_held && (plain_c == kbsc_pkg::CHAR_C))
                begin
                    has_event     = 1'b1;
                    ev.event_kind = kbsc_pkg::EV_INTR;
                end
                else
                begin
                    has_event    = (final_c != '0);
                    ev.char_code = final_c;
                end
            end
        end
    end

endmodule

### src/keyboard_scancode_to_ascii.sv
// keyboard_scancode_to_ascii
// turns raw ps/2 scan code set 1 bytes into keyboard events
//
// input stream: one scan byte per beat on s_tdata[7:0]
// output stream: one event per beat; m_tuser carries the event kind
//   (character, clear screen, interrupt, terminal switch), m_tdata the
//   character code and the terminal number
// modifier presses, releases, swallowed keys and unmapped codes give no beat
//
// a byte taken into the input register is decoded into the result register once
//   that register has room, and its event beat is then offered on the output
// throughput: one byte per cycle while the output is not stalled, set by the
//   single decode stage between the input register and the result register
// a stalled output beat holds, and so does the byte in the input register;
//   s_tready drops once that register is full and resumes as the result
//   register frees up
// reset clears the shift, ctrl, alt and caps lock flags and empties both
//   registers
module keyboard_scancode_to_ascii
(
    input  logic                              clk,
    input  logic                              rst_n,
    // scan_byte [7:0]
    input  logic [kbsc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // char_code [6:0], terminal_number [8:7], zero pad [15:9]
    output logic [kbsc_pkg::M_TDATA_W-1:0]    m_tdata,
    // event_kind [1:0]
    output logic [kbsc_pkg::KIND_W-1:0]       m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready
);

    // input register
    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic [kbsc_pkg::SCAN_W-1:0]     in_byte_reg;

    // keyboard state
    kbsc_pkg::flags_t                flags_reg;
    kbsc_pkg::flags_t                flags_next;

    // result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    kbsc_pkg::event_t                out_event_reg;

    logic                            has_event;
    kbsc_pkg::event_t                dec_event;
    logic                            out_free;
    logic                            process;

    kbsc_decode u_decode
    (
        .scan_byte  (in_byte_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .has_event  (has_event),
        .ev         (dec_event)
    );

    // the held byte is decoded once the result register has room
    assign out_free = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || process;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = process && has_event;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (process)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata[kbsc_pkg::SCAN_W-1:0];
        end
        if (process && has_event)
        begin
            out_event_reg <= dec_event;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg.event_kind;
    assign m_tdata  = {{(kbsc_pkg::M_TDATA_W - kbsc_pkg::CHAR_W - kbsc_pkg::TERM_W){1'b0}},
                       out_event_reg.terminal_number, out_event_reg.char_code};

endmodule

### src/kbsc_checker.sv
module kbsc_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic [kbsc_pkg::M_TDATA_W-1:0]    m_tdata,
    input logic [kbsc_pkg::KIND_W-1:0]       m_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready
);

    // a stalled beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output beat changed while stalled");

    // non-character events carry no character code
    a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != kbsc_pkg::EV_CHAR))
            |-> (m_tdata[kbsc_pkg::CHAR_W-1:0] == '0))
        else $error("character code on a non-character event");

    // terminal number only on terminal switch, and never 3
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == kbsc_pkg::EV_TERM)
            ? (m_tdata[kbsc_pkg::CHAR_W+kbsc_pkg::TERM_W-1:kbsc_pkg::CHAR_W] != 2'd3)
            : (m_tdata[kbsc_pkg::CHAR_W+kbsc_pkg::TERM_W-1:kbsc_pkg::CHAR_W] == '0)))
        else $error("bad terminal number");

    // a character event never carries a zero code
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == kbsc_pkg::EV_CHAR))
            |-> (m_tdata[kbsc_pkg::CHAR_W-1:0] != '0))
        else $error("zero character emitted");

    // the input side never waits while the output side can move
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled with a free output side");

endmodule

bind keyboard_scancode_to_ascii kbsc_checker u_kbsc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

### dv/keyboard_scancode_to_ascii_tb.sv
`timescale 1ns / 1ps

module keyboard_scancode_to_ascii_tb;

    // cycles with no beat on either side before the run is called hung
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned RANDOM_BEATS = 1900;
    // a byte passes only the input and result registers before its event shows, so these spare edges suffice
    localparam int unsigned DRAIN_EDGES  = 8;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef logic [kbsc_pkg::SCAN_W-1:0] scan_t;

    // one directed stimulus row; typed rows carry their own expected event
    typedef struct packed {
        logic [kbsc_pkg::SCAN_W-1:0] scan;
        logic                        typed;
        logic                        fires;
        logic [kbsc_pkg::KIND_W-1:0] kind;
        logic [kbsc_pkg::CHAR_W-1:0] chr;
        logic [kbsc_pkg::TERM_W-1:0] term;
    } stim_row_t;

    localparam int unsigned N_DIRECTED = 26;

    localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
        // extremes of the byte, then a plain letter right after reset
        '{8'h00, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'hFF, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h1E, 1'b1, 1'b1, kbsc_pkg::EV_CHAR, 7'h61, kbsc_pkg::TERM_0},
        // alt held: f1..f3 switch terminals, anything else is swallowed
        '{kbsc_pkg::SC_LALT_DN, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_F1, 1'b1, 1'b1, kbsc_pkg::EV_TERM, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_F2, 1'b1, 1'b1, kbsc_pkg::EV_TERM, 7'h00, kbsc_pkg::TERM_1},
        '{kbsc_pkg::SC_F3, 1'b1, 1'b1, kbsc_pkg::EV_TERM, 7'h00, kbsc_pkg::TERM_2},
        '{8'h1E, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_LALT_UP, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        // ctrl held: l clears, c interrupts, other keys map normally
        '{kbsc_pkg::SC_LCTRL_DN, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h26, 1'b1, 1'b1, kbsc_pkg::EV_CLEAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h2E, 1'b1, 1'b1, kbsc_pkg::EV_INTR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h1E, 1'b0, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_F1, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_LCTRL_UP, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        // shift plus caps lock: letters go back to lower case, brackets stay shifted
        '{kbsc_pkg::SC_LSHIFT_DN, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h1A, 1'b0, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_CAPS, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h1E, 1'b0, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h1A, 1'b0, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_LSHIFT_UP, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h10, 1'b0, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_CAPS, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        // right shift on a digit
        '{kbsc_pkg::SC_RSHIFT_DN, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{8'h02, 1'b0, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0},
        '{kbsc_pkg::SC_RSHIFT_UP, 1'b1, 1'b0, kbsc_pkg::EV_CHAR, 7'h00, kbsc_pkg::TERM_0}
    };

    // key layouts indexed by scan code, zero where no character is mapped
    localparam logic [kbsc_pkg::CHAR_W-1:0] UNSHIFTED_KEYS [0:58] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h00, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h20, 7'h00
    };

    localparam logic [kbsc_pkg::CHAR_W-1:0] SHIFTED_KEYS [0:58] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h20, 7'h00
    };

    logic                            clk;
    logic                            rst_n;
    logic [kbsc_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [kbsc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [kbsc_pkg::KIND_W-1:0]     m_tuser;
    logic                            m_tvalid;
    logic                            m_tready;

    // modifier flags as the testbench tracks them
    kbsc_pkg::flags_t  kb_flags;
    // events still owed by the block, oldest first
    kbsc_pkg::event_t  pending_events [$];
    // when set, neither side inserts idle cycles
    bit          calm;
    int unsigned faults;
    int unsigned scans_sent;
    int unsigned events_seen;
    int unsigned kind_count [0:3];
    int unsigned quiet_edges;

    keyboard_scancode_to_ascii i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),    // scan_byte [7:0]
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),    // char_code [6:0], terminal_number [8:7], pad [15:9]
        .m_tuser  (m_tuser),    // event_kind [1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // decode one scan byte against the tracked flags; returns 1 when an event results
    function automatic bit decode_scan(input logic [kbsc_pkg::SCAN_W-1:0] code,
                                       output kbsc_pkg::event_t ev);
        logic [kbsc_pkg::CHAR_W-1:0] ch;
        ev = '0;
        case (code)
            kbsc_pkg::SC_CAPS:
            begin
                kb_flags.caps_on = ~kb_flags.caps_on;
                return 1'b0;
            end
            kbsc_pkg::SC_LCTRL_DN:
            begin
                kb_flags.ctrl_held = 1'b1;
                return 1'b0;
            end
            kbsc_pkg::SC_LALT_DN:
            begin
                kb_flags.alt_held = 1'b1;
                return 1'b0;
            end
            kbsc_pkg::SC_LSHIFT_DN, kbsc_pkg::SC_RSHIFT_DN:
            begin
                kb_flags.shift_held = 1'b1;
                return 1'b0;
            end
            // releases clear the flag and then fall through; they sit above the tables
            kbsc_pkg::SC_LCTRL_UP: kb_flags.ctrl_held = 1'b0;
            kbsc_pkg::SC_LALT_UP:  kb_flags.alt_held  = 1'b0;
            kbsc_pkg::SC_LSHIFT_UP, kbsc_pkg::SC_RSHIFT_UP: kb_flags.shift_held = 1'b0;
            default: ;
        endcase

        // alt swallows everything but the terminal switch keys
        if (kb_flags.alt_held)
        begin
            ev.event_kind = kbsc_pkg::EV_TERM;
            if (code == kbsc_pkg::SC_F1)
            begin
                ev.terminal_number = kbsc_pkg::TERM_0;
                return 1'b1;
            end
            if (code == kbsc_pkg::SC_F2)
            begin
                ev.terminal_number = kbsc_pkg::TERM_1;
                return 1'b1;
            end
            if (code == kbsc_pkg::SC_F3)
            begin
                ev.terminal_number = kbsc_pkg::TERM_2;
                return 1'b1;
            end
            ev = '0;
            return 1'b0;
        end

        if (code >= kbsc_pkg::MAP_SIZE)
            return 1'b0;

        // ctrl shortcuts look at the unshifted key only
        if (kb_flags.ctrl_held)
        begin
            if (UNSHIFTED_KEYS[code] == kbsc_pkg::CHAR_L)
            begin
                ev.event_kind = kbsc_pkg::EV_CLEAR;
                return 1'b1;
            end
            if (UNSHIFTED_KEYS[code] == kbsc_pkg::CHAR_C)
            begin
                ev.event_kind = kbsc_pkg::EV_INTR;
                return 1'b1;
            end
        end

        ch = kb_flags.shift_held ? SHIFTED_KEYS[code] : UNSHIFTED_KEYS[code];
        // caps lock flips the case of letters and nothing else
        if (kb_flags.caps_on)
        begin
            if (ch >= kbsc_pkg::CHAR_LO_A && ch <= kbsc_pkg::CHAR_LO_Z)
                ch = ch - kbsc_pkg::CASE_BIT;
            else if (ch >= kbsc_pkg::CHAR_UP_A && ch <= kbsc_pkg::CHAR_UP_Z)
                ch = ch + kbsc_pkg::CASE_BIT;
        end
        if (ch == '0)
            return 1'b0;
        ev.event_kind = kbsc_pkg::EV_CHAR;
        ev.char_code  = ch;
        return 1'b1;
    endfunction

    task automatic flag_fault(input string msg);
        faults++;
        if (faults <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // mostly realistic typing: table keys, modifier presses and releases,
    // key releases, terminal keys, ctrl shortcuts and the odd arbitrary byte
    function automatic logic [kbsc_pkg::SCAN_W-1:0] pick_scan_byte();
        int unsigned r;
        logic [kbsc_pkg::SCAN_W-1:0] b;
        r = $urandom_range(0, 99);
        if (r < 50)
            b = scan_t'($urandom_range(0, 58));
        else if (r < 65)
        begin
            // releases outnumber presses so alt does not swallow most of the run
            case ($urandom_range(0, 11))
                0:       b = kbsc_pkg::SC_CAPS;
                1:       b = kbsc_pkg::SC_LCTRL_DN;
                2, 3:    b = kbsc_pkg::SC_LCTRL_UP;
                4:       b = kbsc_pkg::SC_LALT_DN;
                5, 6, 7: b = kbsc_pkg::SC_LALT_UP;
                8:       b = kbsc_pkg::SC_LSHIFT_DN;
                9:       b = kbsc_pkg::SC_LSHIFT_UP;
                10:      b = kbsc_pkg::SC_RSHIFT_DN;
                default: b = kbsc_pkg::SC_RSHIFT_UP;
            endcase
        end
        else if (r < 72)
            b = kbsc_pkg::SC_F1 + scan_t'($urandom_range(0, 2));
        else if (r < 85)
            b = 8'h80 | scan_t'($urandom_range(0, 58));
        else if (r < 92)
            b = $urandom_range(0, 1) ? 8'h26 : 8'h2E;
        else
            b = scan_t'($urandom_range(0, 255));
        return b;
    endfunction

    // offer one beat, wait for acceptance, then record what the block owes
    task automatic send_scan(input logic [kbsc_pkg::SCAN_W-1:0] b, input bit typed,
                             input bit fires, input kbsc_pkg::event_t typed_ev);
        kbsc_pkg::event_t ev;
        bit               fired;
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scans_sent++;
        fired = decode_scan(b, ev);
        // typed rows override the expectation but the flags still follow the byte
        if (typed)
        begin
            fired = fires;
            ev    = typed_ev;
        end
        if (fired)
        begin
            pending_events.push_back(ev);
            kind_count[ev.event_kind]++;
        end
    endtask

    // receiver: random stall bursts, none while calm
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // output checker: every event beat against the oldest owed event
    always @(posedge clk)
    begin
        kbsc_pkg::event_t got;
        kbsc_pkg::event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            events_seen++;
            got.event_kind      = m_tuser;
            got.char_code       = m_tdata[kbsc_pkg::CHAR_W-1:0];
            got.terminal_number = m_tdata[kbsc_pkg::CHAR_W+kbsc_pkg::TERM_W-1:kbsc_pkg::CHAR_W];
            if (pending_events.size() == 0)
                flag_fault($sformatf("unexpected event beat: kind %0d char %h term %0d",
                                     got.event_kind, got.char_code, got.terminal_number));
            else
            begin
                want = pending_events.pop_front();
                if (got.event_kind != want.event_kind || got.char_code != want.char_code
                    || got.terminal_number != want.terminal_number
                    || m_tdata[kbsc_pkg::M_TDATA_W-1:kbsc_pkg::CHAR_W+kbsc_pkg::TERM_W] != '0)
                    flag_fault($sformatf({"event mismatch: expected kind %0d char %h term %0d,",
                                          " got kind %0d char %h term %0d pad %h"},
                                         want.event_kind, want.char_code,
                                         want.terminal_number, got.event_kind, got.char_code,
                                         got.terminal_number,
                                         m_tdata[kbsc_pkg::M_TDATA_W-1:
                                                 kbsc_pkg::CHAR_W+kbsc_pkg::TERM_W]));
            end
        end
    end

    // watchdog: too long with no beat on either side means the block is stuck
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_edges <= 0;
        else if (quiet_edges >= STALL_LIMIT)
        begin
            $display("timeout: no beat for %0d cycles, %0d events still owed",
                     quiet_edges, pending_events.size());
            $display("keyboard_scancode_to_ascii_tb failed");
            $finish;
        end
        else
            quiet_edges <= quiet_edges + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        kb_flags    = '0;
        faults      = 0;
        scans_sent  = 0;
        events_seen = 0;
        kind_count  = '{0, 0, 0, 0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows first
        for (int i = 0; i < N_DIRECTED; i++)
            send_scan(DIRECTED[i].scan, DIRECTED[i].typed, DIRECTED[i].fires,
                      '{DIRECTED[i].kind, DIRECTED[i].chr, DIRECTED[i].term});

        // random typing; every fourth block of 100 and the tail run without idling
        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            calm = ((i / 100) % 4 == 3) || (i >= RANDOM_BEATS - 200);
            send_scan(pick_scan_byte(), 1'b0, 1'b0, '0);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then leave room for any stray beat
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_EDGES) @(posedge clk);
        if (pending_events.size() != 0)
            flag_fault($sformatf("%0d events never arrived", pending_events.size()));

        $display("%0d scan bytes sent, %0d event beats checked", scans_sent, events_seen);
        $display("events by kind: char %0d, clear %0d, interrupt %0d, terminal %0d, faults %0d",
                 kind_count[kbsc_pkg::EV_CHAR], kind_count[kbsc_pkg::EV_CLEAR],
                 kind_count[kbsc_pkg::EV_INTR], kind_count[kbsc_pkg::EV_TERM], faults);
        if (faults == 0)
            $display("keyboard_scancode_to_ascii_tb passed");
        else
            $display("keyboard_scancode_to_ascii_tb failed");
        $finish;
    end

endmodule

### files.f
src/kbsc_pkg.sv
src/kbsc_decode.sv
src/keyboard_scancode_to_ascii.sv
src/kbsc_checker.sv
dv/keyboard_scancode_to_ascii_tb.sv
